/* hdl/ila_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ila_pkg;

  localparam int IN_TIME_W  = 32;
  localparam int LANE_W     = 6;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 7;
  localparam int SPAN_W     = 32;

  typedef enum logic [STATUS_W-1:0] {
    ST_REUSE    = 2'd0,
    ST_OPEN     = 2'd1,
    ST_OVERFLOW = 2'd2
  } ila_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } ila_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } ila_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic out_busy;
  } ila_sts_t;

endpackage

`default_nettype wire

/* hdl/ila_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface ila_in_if;
  import ila_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [IN_TIME_W-1:0] start_ms;
  logic [IN_TIME_W-1:0] end_ms;
  logic                 new_set;

  modport source (output valid, start_ms, end_ms, new_set, input ready);
  modport sink   (input valid, start_ms, end_ms, new_set, output ready);
endinterface

interface ila_out_if;
  import ila_pkg::*;
  logic                valid;
  logic                ready;
  logic [LANE_W-1:0]   lane;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  lane_count;
  logic [SPAN_W-1:0]   span_start;
  logic [SPAN_W-1:0]   span_end;

  modport source (output valid, lane, status, lane_count, span_start, span_end,
                  input ready);
  modport sink   (input valid, lane, status, lane_count, span_start, span_end,
                  output ready);
endinterface

`default_nettype wire

/* hdl/ila_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module ila_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hdl/ila_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module ila_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire ila_pkg::ila_sts_t sts,
  output ila_pkg::ila_cmd_t      cmd
);
  import ila_pkg::*;

  ila_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        // hold until the output register can take the result
        if (!sts.out_busy) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
      end
      S_FINISH: begin
        cmd.finish = !sts.out_busy;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hdl/ila_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module ila_dp #(
  parameter int MAX_LANES  = 64,
  parameter int TIME_WIDTH = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire ila_pkg::ila_cmd_t               cmd,
  output ila_pkg::ila_sts_t                    sts,
  input  wire logic [ila_pkg::IN_TIME_W-1:0]   in_start_ms,
  input  wire logic [ila_pkg::IN_TIME_W-1:0]   in_end_ms,
  input  wire logic                            in_new_set,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [ila_pkg::LANE_W-1:0]           out_lane,
  output logic [ila_pkg::STATUS_W-1:0]         out_status,
  output logic [ila_pkg::COUNT_W-1:0]          out_lane_count,
  output logic [ila_pkg::SPAN_W-1:0]           out_span_start,
  output logic [ila_pkg::SPAN_W-1:0]           out_span_end
);
  import ila_pkg::*;

  localparam int LW  = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
  localparam int CW  = $clog2(MAX_LANES + 1);
  localparam int TW  = TIME_WIDTH;
  localparam int LWX = (LW > LANE_W) ? LW : LANE_W;
  localparam int CWX = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int TWX = (TW > SPAN_W) ? TW : SPAN_W;
  localparam logic [CW-1:0] FULL = CW'(MAX_LANES);

  logic [TW-1:0]  start_r, end_r;
  logic [TW-1:0]  min_r, min_nxt;
  logic [TW-1:0]  max_r, max_nxt;
  logic [CW-1:0]  used_r, used_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           rdv_r;
  logic [LW-1:0]  rdidx_r;
  logic           found_r, found_nxt;
  logic [LW-1:0]  pick_r, pick_nxt;
  logic [TW-1:0]  best_r, best_nxt;

  logic           issue, hit, empty;
  logic [TW-1:0]  start_in, end_in, rd_data;
  logic           wr_en;
  logic [LW-1:0]  wr_addr;
  logic [TW-1:0]  wr_data;

  logic                out_valid_r, out_valid_nxt;
  logic [LWX-1:0]      lane_r;
  ila_status_t         status_r;
  logic [CWX-1:0]      count_r;
  logic [TWX-1:0]      span_s_r, span_e_r;

  assign start_in = TW'(in_start_ms);
  assign end_in   = TW'(in_end_ms);

  ila_ram #(
    .WIDTH (TW),
    .DEPTH (MAX_LANES),
    .AW    (LW)
  ) u_lane_end (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (issue),
    .raddr (cnt_r[LW-1:0]),
    .rdata (rd_data)
  );

  // one read issued per cycle, compared when it returns
  assign issue = cmd.scan && (cnt_r < used_r);
  assign hit   = rdv_r && (rd_data <= start_r) && (!found_r || rd_data < best_r);

  assign sts.scan_done = (cnt_r == used_r) && !rdv_r;
  assign sts.out_busy  = out_valid_r && !out_ready;

  assign empty = in_new_set || (used_r == '0);

  always_comb begin
    min_nxt   = min_r;
    max_nxt   = max_r;
    used_nxt  = used_r;
    cnt_nxt   = cnt_r;
    found_nxt = found_r;
    pick_nxt  = pick_r;
    best_nxt  = best_r;
    wr_en     = 1'b0;
    wr_addr   = used_r[LW-1:0];
    wr_data   = end_r;

    if (cmd.load) begin
      cnt_nxt   = '0;
      found_nxt = 1'b0;
      if (in_new_set) begin
        used_nxt = '0;
      end
      if (empty) begin
        min_nxt = start_in;
        max_nxt = end_in;
      end else begin
        if (start_in < min_r) begin
          min_nxt = start_in;
        end
        if (end_in > max_r) begin
          max_nxt = end_in;
        end
      end
    end

    if (issue) begin
      cnt_nxt = cnt_r + 1'b1;
    end

    if (hit) begin
      found_nxt = 1'b1;
      pick_nxt  = rdidx_r;
      best_nxt  = rd_data;
    end

    if (cmd.finish) begin
      if (found_r) begin
        wr_en   = 1'b1;
        wr_addr = pick_r;
        wr_data = (end_r > best_r) ? end_r : best_r;
      end else if (used_r != FULL) begin
        wr_en    = 1'b1;
        used_nxt = used_r + 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      min_r       <= '0;
      max_r       <= '0;
      rdv_r       <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      used_r      <= used_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      rdv_r       <= issue;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      start_r <= start_in;
      end_r   <= end_in;
    end
    rdidx_r <= cnt_r[LW-1:0];
    found_r <= found_nxt;
    pick_r  <= pick_nxt;
    best_r  <= best_nxt;
    if (cmd.finish) begin
      count_r  <= CWX'(used_nxt);
      span_s_r <= TWX'(min_r);
      span_e_r <= TWX'(max_r);
      if (found_r) begin
        lane_r   <= LWX'(pick_r);
        status_r <= ST_REUSE;
      end else if (used_r != FULL) begin
        lane_r   <= LWX'(used_r[LW-1:0]);
        status_r <= ST_OPEN;
      end else begin
        lane_r   <= '0;
        status_r <= ST_OVERFLOW;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_lane       = lane_r[LANE_W-1:0];
  assign out_status     = status_r;
  assign out_lane_count = count_r[COUNT_W-1:0];
  assign out_span_start = span_s_r[SPAN_W-1:0];
  assign out_span_end   = span_e_r[SPAN_W-1:0];

endmodule

`default_nettype wire

/* hdl/interval_lane_assigner_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake            Transaction
// in_ch     in   in_ch.valid/ready    start_ms, end_ms, new_set
// out_ch    out  out_ch.valid/ready   lane, status, lane_count, span_start, span_end
//
// One interval per transaction, one result per interval. After acceptance an
// interval is loaded, scanned against every lane in use and then finished
// before its result is registered: the lane-end memory is read once per cycle
// with a registered read port, and each returned end is compared in the cycle after.
// Synchronous active-low reset clears the lane count, the span and the
// handshake state; the lane-end memory needs no clearing.
// A new interval is taken while the previous result waits in the output
// register; a held result stalls only the final write of the next one.

module interval_lane_assigner_unit #(
  parameter int MAX_LANES  = 64,
  parameter int TIME_WIDTH = 32
) (
  input wire logic clk,
  input wire logic rst_n,
  ila_in_if.sink   in_ch,
  ila_out_if.source out_ch
);
  import ila_pkg::*;

  ila_cmd_t cmd;
  ila_sts_t sts;
  logic     in_ready;

  assign in_ch.ready = in_ready;

  ila_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ila_dp #(
    .MAX_LANES  (MAX_LANES),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_start_ms    (in_ch.start_ms),
    .in_end_ms      (in_ch.end_ms),
    .in_new_set     (in_ch.new_set),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_lane       (out_ch.lane),
    .out_status     (out_ch.status),
    .out_lane_count (out_ch.lane_count),
    .out_span_start (out_ch.span_start),
    .out_span_end   (out_ch.span_end)
  );

endmodule

`default_nettype wire

/* bench/tb_interval_lane_assigner_unit.sv */
`timescale 1ns / 1ps

module tb_interval_lane_assigner_unit;
  import ila_pkg::*;

  localparam int LANE_LIMIT   = 64;
  localparam int RANDOM_ITEMS = 750;
  localparam int MAX_PAUSE    = 12;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int REPORT_LIMIT = 10;

  typedef struct {
    logic [IN_TIME_W-1:0] start_ms;
    logic [IN_TIME_W-1:0] end_ms;
    logic                 new_set;
  } interval_t;

  typedef struct {
    logic [LANE_W-1:0]  lane;
    ila_status_t        status;
    logic [COUNT_W-1:0] lane_count;
    logic [SPAN_W-1:0]  span_start;
    logic [SPAN_W-1:0]  span_end;
  } lane_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ila_in_if  in_ch ();
  ila_out_if out_ch ();

  interval_lane_assigner_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  interval_t    interval_q[$];
  lane_result_t lane_results_q[$];

  // lane allocation state as the block should hold it
  logic [IN_TIME_W-1:0] lane_ends [0:LANE_LIMIT-1];
  int                   lanes_in_use = 0;
  logic [IN_TIME_W-1:0] span_lo = '0;
  logic [IN_TIME_W-1:0] span_hi = '0;

  int        total_items = 0;
  int        accepted_cnt = 0;
  int        checked_cnt = 0;
  int        fail_cnt = 0;
  int        cycle_cnt = 0;
  interval_t in_item;
  int        in_gap_left = 0;
  int        out_stall_left = 0;
  bit        in_steady = 1'b0;
  bit        out_steady = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d intervals accepted",
               cycle_cnt, accepted_cnt, total_items);
      $display("FAIL interval_lane_assigner_unit");
      $finish;
    end
  end

  function automatic int draw_pause(input bit steady);
    return steady ? 0 : int'($urandom_range(0, MAX_PAUSE));
  endfunction

  task automatic add_interval(input logic [31:0] s, input logic [31:0] e, input logic ns);
    interval_t iv;
    iv.start_ms = s;
    iv.end_ms   = e;
    iv.new_set  = ns;
    interval_q.push_back(iv);
    total_items++;
  endtask

  // Reuse free lane with earliest end (lowest index on tie), else open or overflow.
  task automatic assign_lane(input interval_t iv);
    lane_result_t r;
    bit           found;
    int           pick;
    logic [31:0]  best;
    found = 1'b0;
    pick  = 0;
    best  = '0;
    if (iv.new_set) begin
      lanes_in_use = 0;
      span_lo      = '0;
      span_hi      = '0;
    end
    if (lanes_in_use == 0) begin
      span_lo = iv.start_ms;
      span_hi = iv.end_ms;
    end else begin
      if (iv.start_ms < span_lo) span_lo = iv.start_ms;
      if (iv.end_ms > span_hi) span_hi = iv.end_ms;
    end
    for (int i = 0; i < lanes_in_use; i++) begin
      if (lane_ends[i] <= iv.start_ms && (!found || lane_ends[i] < best)) begin
        found = 1'b1;
        pick  = i;
        best  = lane_ends[i];
      end
    end
    if (found) begin
      if (iv.end_ms > lane_ends[pick]) lane_ends[pick] = iv.end_ms;
      r.lane   = LANE_W'(pick);
      r.status = ST_REUSE;
    end else if (lanes_in_use < LANE_LIMIT) begin
      lane_ends[lanes_in_use] = iv.end_ms;
      r.lane   = LANE_W'(lanes_in_use);
      r.status = ST_OPEN;
      lanes_in_use++;
    end else begin
      r.lane   = '0;
      r.status = ST_OVERFLOW;
    end
    r.lane_count = COUNT_W'(lanes_in_use);
    r.span_start = span_lo;
    r.span_end   = span_hi;
    lane_results_q.push_back(r);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid    <= 1'b0;
      in_ch.start_ms <= '0;
      in_ch.end_ms   <= '0;
      in_ch.new_set  <= 1'b0;
      in_gap_left    = draw_pause(in_steady);
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        assign_lane(in_item);
        accepted_cnt++;
        if ($urandom_range(0, 49) == 0) in_steady = !in_steady;
        in_gap_left = draw_pause(in_steady);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap_left > 0) begin
          in_ch.valid <= 1'b0;
          in_gap_left--;
        end else if (interval_q.size() > 0) begin
          in_item = interval_q.pop_front();
          in_ch.valid    <= 1'b1;
          in_ch.start_ms <= in_item.start_ms;
          in_ch.end_ms   <= in_item.end_ms;
          in_ch.new_set  <= in_item.new_set;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    lane_result_t exp_r;
    if (!rst_n) begin
      out_ch.ready   <= 1'b0;
      out_stall_left = draw_pause(out_steady);
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (lane_results_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= REPORT_LIMIT)
            $display("unexpected lane result: lane=%0d status=%0d count=%0d",
                     out_ch.lane, out_ch.status, out_ch.lane_count);
        end else begin
          exp_r = lane_results_q.pop_front();
          if (out_ch.lane !== exp_r.lane || out_ch.status !== exp_r.status ||
              out_ch.lane_count !== exp_r.lane_count ||
              out_ch.span_start !== exp_r.span_start ||
              out_ch.span_end !== exp_r.span_end) begin
            fail_cnt++;
            if (fail_cnt <= REPORT_LIMIT) begin
              $display("lane result %0d mismatch", checked_cnt);
              $display("  expected lane=%0d status=%0d count=%0d span=%h..%h",
                       exp_r.lane, exp_r.status, exp_r.lane_count,
                       exp_r.span_start, exp_r.span_end);
              $display("  actual   lane=%0d status=%0d count=%0d span=%h..%h",
                       out_ch.lane, out_ch.status, out_ch.lane_count,
                       out_ch.span_start, out_ch.span_end);
            end
          end
        end
        checked_cnt++;
        if ($urandom_range(0, 49) == 0) out_steady = !out_steady;
        out_stall_left = draw_pause(out_steady);
      end
      // count down the stall only while a result is on offer
      if (out_stall_left > 0) begin
        out_ch.ready <= 1'b0;
        if (out_ch.valid) out_stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    logic [31:0] t;
    logic [31:0] last_t;
    int          n;
    int          step_max;
    int          dur_max;
    int          pick_kind;
    bit          first_set;

    in_ch.valid    = 1'b0;
    in_ch.start_ms = '0;
    in_ch.end_ms   = '0;
    in_ch.new_set  = 1'b0;
    out_ch.ready   = 1'b0;

    // first set starts right after reset, without new_set
    add_interval(32'd100, 32'd200, 1'b0);
    add_interval(32'd150, 32'd300, 1'b0);
    add_interval(32'd160, 32'd300, 1'b0);
    add_interval(32'd300, 32'd400, 1'b0);   // reuse the earliest end
    add_interval(32'd350, 32'd360, 1'b0);   // tie between two lanes
    add_interval(32'd50, 32'd40, 1'b0);     // end before start, span start drops
    add_interval(32'd60, 32'd10, 1'b0);     // reused lane keeps its larger end
    add_interval(32'd0, 32'd0, 1'b1);
    add_interval(32'd0, 32'd0, 1'b0);
    add_interval(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    add_interval(32'hFFFF_FFFF, 32'd0, 1'b1);
    add_interval(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    add_interval(32'd0, 32'hFFFF_FFFF, 1'b0);
    add_interval(32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
    add_interval(32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
    last_t = 32'h5555_5555;

    first_set = 1'b1;
    while (total_items < 15 + RANDOM_ITEMS) begin
      pick_kind = first_set ? 0 : int'($urandom_range(0, 19));
      first_set = 1'b0;
      if (pick_kind == 0) begin
        // pile of overlapping intervals: fill every lane, then overflow
        n = $urandom_range(66, 80);
        t = $urandom_range(0, 32'h7FFF_FFFF);
        for (int k = 0; k < n; k++) begin
          t = t + $urandom_range(0, 3);
          add_interval(t, t + 32'h0100_0000 + $urandom_range(0, 255), k == 0);
        end
        last_t = t;
      end else if (pick_kind <= 15) begin
        // ordered set; a continuation keeps the current table
        n = (pick_kind <= 12) ? $urandom_range(1, 40) : $urandom_range(1, 10);
        case ($urandom_range(0, 2))
          0: begin step_max = 4;     dur_max = 16;      end
          1: begin step_max = 200;   dur_max = 1000;    end
          default: begin step_max = 1 << 18; dur_max = 1 << 21; end
        endcase
        if (pick_kind > 12) t = last_t;
        else t = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1000);
        for (int k = 0; k < n; k++) begin
          t = t + $urandom_range(0, step_max);
          add_interval(t, t + $urandom_range(0, dur_max), pick_kind <= 12 && k == 0);
        end
        last_t = t;
      end else begin
        // noise: unordered, any values
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++)
          add_interval($urandom, $urandom, $urandom_range(0, 3) == 0);
        last_t = $urandom;
      end
    end

    @(posedge clk);
    while (!rst_n) @(posedge clk);
    while (accepted_cnt < total_items || lane_results_q.size() != 0) @(posedge clk);
    repeat (LANE_LIMIT + 16) @(posedge clk);
    if (lane_results_q.size() != 0) fail_cnt++;
    if (fail_cnt == 0) begin
      $display("PASS interval_lane_assigner_unit");
    end else begin
      $display("FAIL interval_lane_assigner_unit");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/ila_pkg.sv
hdl/ila_if.sv
hdl/ila_ram.sv
hdl/ila_ctrl.sv
hdl/ila_dp.sv
hdl/interval_lane_assigner_unit.sv
bench/tb_interval_lane_assigner_unit.sv
